>>> rtl/plist_pkg.sv
// Shared types, codes and tree sizing helpers for the positional list engine.
package plist_pkg;

  localparam int unsigned DefaultCapacity = 64;
  localparam int unsigned ValueW = 32;
  localparam int unsigned PosW = 7;
  localparam int unsigned TreeFanIn = 8;

  localparam logic [1:0] ACT_READ   = 2'd0;
  localparam logic [1:0] ACT_INSERT = 2'd1;
  localparam logic [1:0] ACT_REMOVE = 2'd2;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_RANGE = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  typedef enum logic {
    S_IDLE,
    S_BUSY
  } plist_state_t;

  typedef struct packed {
    logic            ins;
    logic            rem;
    logic            rd;
    logic [PosW-1:0] pos;
  } plist_cmd_t;

  function automatic int unsigned tree_levels(input int unsigned n);
    int unsigned w;
    int unsigned l;
    w = n;
    l = 0;
    while (w > 1) begin
      w = (w + TreeFanIn - 1) / TreeFanIn;
      l = l + 1;
    end
    return l;
  endfunction

  function automatic int unsigned level_width(input int unsigned n, input int unsigned lvl);
    int unsigned w;
    w = n;
    for (int unsigned i = 0; i < lvl; i++) begin
      w = (w + TreeFanIn - 1) / TreeFanIn;
    end
    return w;
  endfunction

  function automatic int unsigned level_offset(input int unsigned n, input int unsigned lvl);
    int unsigned off;
    off = 0;
    for (int unsigned i = 0; i < lvl; i++) begin
      off = off + level_width(n, i);
    end
    return off;
  endfunction

endpackage

>>> rtl/plist_cell.sv
// One storage cell of the shifting chain: holds one entry and its read tap.
module plist_cell import plist_pkg::*; #(
  parameter int unsigned INDEX = 0
) (
  input  logic              clk,
  input  plist_cmd_t        cmd,
  input  logic [ValueW-1:0] value,
  input  logic [ValueW-1:0] left,
  input  logic [ValueW-1:0] right,
  output logic [ValueW-1:0] data,
  output logic [ValueW-1:0] tap
);

  logic eq;
  logic gt;
  logic ge;

  assign eq = (32'(cmd.pos) == INDEX);
  assign gt = (32'(cmd.pos) < INDEX);
  assign ge = eq || gt;

  always_ff @(posedge clk) begin
    if (cmd.ins && gt) begin
      data <= left;
    end else if (cmd.ins && eq) begin
      data <= value;
    end else if (cmd.rem && ge) begin
      data <= right;
    end
  end

  assign tap = (cmd.rd && eq) ? data : '0;

endmodule

>>> rtl/plist_or_tree.sv
// Registered OR-reduction tree that collects the single active read tap.
module plist_or_tree import plist_pkg::*; #(
  parameter int unsigned N = DefaultCapacity
) (
  input  logic              clk,
  input  logic              en,
  input  logic [ValueW-1:0] leaf [N],
  output logic [ValueW-1:0] root
);

  localparam int unsigned Levels = tree_levels(N);
  localparam int unsigned Total  = level_offset(N, Levels + 1);

  logic [ValueW-1:0] node [Total];

  for (genvar j = 0; j < N; j++) begin : g_leaf
    always_ff @(posedge clk) begin
      if (en) begin
        node[j] <= leaf[j];
      end
    end
  end

  for (genvar l = 1; l <= Levels; l++) begin : g_lvl
    localparam int unsigned Off  = level_offset(N, l);
    localparam int unsigned POff = level_offset(N, l - 1);
    localparam int unsigned PW   = level_width(N, l - 1);
    localparam int unsigned W    = level_width(N, l);
    for (genvar j = 0; j < W; j++) begin : g_node
      logic [ValueW-1:0] kids [TreeFanIn];
      logic [ValueW-1:0] or_val;
      for (genvar k = 0; k < TreeFanIn; k++) begin : g_kid
        if (j * TreeFanIn + k < PW) begin : g_use
          assign kids[k] = node[POff + j * TreeFanIn + k];
        end else begin : g_pad
          assign kids[k] = '0;
        end
      end
      always_comb begin
        or_val = '0;
        for (int k = 0; k < TreeFanIn; k++) begin
          or_val = or_val | kids[k];
        end
      end
      always_ff @(posedge clk) begin
        node[Off + j] <= or_val;
      end
    end
  end

  assign root = node[Total - 1];

endmodule

>>> rtl/positional_list_engine.sv
// Top level of the positional list engine: control, count and the cell chain.
// Ordered store of up to CAPACITY signed 32-bit values addressed by position.
// Insert shifts the cells above the position away from it and remove shifts
// the cells at and above it toward it, in the accept cycle; a read gates the
// addressed cell onto a registered OR tree of ceil(log8(CAPACITY)) levels.
// A new item is accepted only once the last result is registered; the
// result register lets the next item enter while a result waits downstream.
// Bad positions and inserts into a full store report status and change nothing.
module positional_list_engine import plist_pkg::*; #(
  parameter int unsigned CAPACITY = DefaultCapacity
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [1:0]               action,
  input  logic [PosW-1:0]          position,
  input  logic signed [ValueW-1:0] value,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic signed [ValueW-1:0] read_value,
  output logic [1:0]               status,
  output logic [PosW-1:0]          entry_count
);

  localparam int unsigned CntW   = $clog2(CAPACITY + 1);
  localparam int unsigned Levels = tree_levels(CAPACITY);
  localparam int unsigned LatW   = (Levels > 0) ? $clog2(Levels + 1) : 1;

  plist_state_t      state;
  plist_state_t      state_next;
  logic [CntW-1:0]   count;
  logic [CntW-1:0]   count_next;
  logic [LatW-1:0]   lat;
  logic [LatW-1:0]   lat_next;
  logic [1:0]        pend_status;
  logic [PosW-1:0]   pend_count;
  logic [1:0]        status_new;
  logic              accept;
  logic              slot_free;
  logic              done;
  logic              pos_lt;
  logic              pos_le;
  logic              full;
  plist_cmd_t        cmd;
  logic [ValueW-1:0] data [CAPACITY];
  logic [ValueW-1:0] taps [CAPACITY];
  logic [ValueW-1:0] root;

  assign accept    = in_valid && in_ready;
  assign slot_free = !out_valid || out_ready;
  assign done      = (state == S_BUSY) && (lat == LatW'(Levels)) && slot_free;

  assign pos_lt = 32'(position) < 32'(count);
  assign pos_le = 32'(position) <= 32'(count);
  assign full   = (count == CntW'(CAPACITY));

  always_comb begin
    cmd.ins    = 1'b0;
    cmd.rem    = 1'b0;
    cmd.rd     = 1'b0;
    cmd.pos    = position;
    status_new = ST_OK;
    case (action)
      ACT_READ: begin
        cmd.rd = accept && pos_lt;
        if (!pos_lt) begin
          status_new = ST_RANGE;
        end
      end
      ACT_INSERT: begin
        if (full) begin
          status_new = ST_FULL;
        end else if (!pos_le) begin
          status_new = ST_RANGE;
        end else begin
          cmd.ins = accept;
        end
      end
      ACT_REMOVE: begin
        cmd.rem = accept && pos_lt;
        if (!pos_lt) begin
          status_new = ST_RANGE;
        end
      end
      default: begin
        status_new = ST_OK;
      end
    endcase
  end

  always_comb begin
    count_next = count;
    if (cmd.ins) begin
      count_next = count + CntW'(1);
    end else if (cmd.rem) begin
      count_next = count - CntW'(1);
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) begin
          state_next = S_BUSY;
        end
      end
      S_BUSY: begin
        if (done) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    lat_next = lat;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        lat_next = '0;
      end
      S_BUSY: begin
        if (lat != LatW'(Levels)) begin
          lat_next = lat + LatW'(1);
        end
      end
      default: begin
        lat_next = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      lat       <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      lat   <= lat_next;
      if (done) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pend_status <= status_new;
      pend_count  <= PosW'(count_next);
    end
    if (done) begin
      read_value  <= root;
      status      <= pend_status;
      entry_count <= pend_count;
    end
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [ValueW-1:0] left;
    logic [ValueW-1:0] right;
    if (i == 0) begin : g_first
      assign left = '0;
    end else begin : g_left
      assign left = data[i - 1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right = data[i];
    end else begin : g_right
      assign right = data[i + 1];
    end
    plist_cell #(
      .INDEX(i)
    ) u_cell (
      .clk  (clk),
      .cmd  (cmd),
      .value(value),
      .left (left),
      .right(right),
      .data (data[i]),
      .tap  (taps[i])
    );
  end

  plist_or_tree #(
    .N(CAPACITY)
  ) u_tree (
    .clk (clk),
    .en  (accept),
    .leaf(taps),
    .root(root)
  );

endmodule

>>> rtl/plist_checker.sv
// Port-level checks for the positional list engine, bound to the top level.
module plist_checker import plist_pkg::*; #(
  parameter int unsigned CAPACITY = DefaultCapacity
) (
  input logic                     clk,
  input logic                     rst,
  input logic                     out_valid,
  input logic                     out_ready,
  input logic signed [ValueW-1:0] read_value,
  input logic [1:0]               status,
  input logic [PosW-1:0]          entry_count
);

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (status == ST_OK || status == ST_RANGE || status == ST_FULL))
    else $error("undefined status code");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(read_value) && $stable(status)
      && $stable(entry_count))
    else $error("stalled result beat changed");

  a_count_cap: assert property (@(posedge clk) disable iff (rst)
    out_valid && (CAPACITY < 128) |-> 32'(entry_count) <= CAPACITY)
    else $error("entry count above capacity");

  a_full_count: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ST_FULL |-> entry_count == PosW'(CAPACITY))
    else $error("full status with store not full");

  a_read_ok: assert property (@(posedge clk) disable iff (rst)
    out_valid && read_value != '0 |-> status == ST_OK)
    else $error("read value on failed item");

endmodule

bind positional_list_engine plist_checker #(.CAPACITY(CAPACITY)) u_plist_checker (.*);

>>> verif/testbench.sv
// Testbench for positional_list_engine: directed table, random insert/remove/read mix, shadow check.
`timescale 1ns / 1ps

module testbench;
  import plist_pkg::*;

  localparam int unsigned LIST_CAP = DefaultCapacity;
  localparam logic [1:0] ACT_NONE = 2'd3;
  localparam int unsigned ITEM_TOTAL = 1150;
  localparam int unsigned QUIET_TAIL = 150;
  localparam int unsigned STALL_LIMIT = 2000;
  localparam int unsigned DRAIN_CYCLES = 20;

  typedef struct packed {
    logic signed [ValueW-1:0] rd;
    logic [1:0]               st;
    logic [PosW-1:0]          cnt;
  } list_result_t;

  typedef struct packed {
    logic [1:0]        act;
    logic [PosW-1:0]   pos;
    logic [ValueW-1:0] val;
    bit                known;
    list_result_t      res;
  } stim_row_t;

  typedef enum int {
    GROW,
    SHRINK,
    MIXED
  } mix_t;

  logic                     clk;
  logic                     rst;
  logic                     in_valid;
  logic                     in_ready;
  logic [1:0]               action;
  logic [PosW-1:0]          position;
  logic signed [ValueW-1:0] value;
  logic                     out_valid;
  logic                     out_ready;
  logic signed [ValueW-1:0] read_value;
  logic [1:0]               status;
  logic [PosW-1:0]          entry_count;

  logic signed [ValueW-1:0] shadow_vals [LIST_CAP];
  int unsigned              shadow_len;
  list_result_t             expected_results [$];
  stim_row_t                directed_rows [$];
  int unsigned              fail_count = 0;
  int unsigned              idle_odds = 0;
  int unsigned              quiet_cycles = 0;

  positional_list_engine #(.CAPACITY(LIST_CAP)) DUT (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .action(action),
    .position(position),
    .value(value),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .read_value(read_value),
    .status(status),
    .entry_count(entry_count)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic list_result_t apply_list_op(input logic [1:0] act,
                                                 input logic [PosW-1:0] pos,
                                                 input logic signed [ValueW-1:0] val);
    list_result_t r;
    r.rd = '0;
    r.st = ST_OK;
    if (act == ACT_READ) begin
      if (pos < shadow_len && pos < LIST_CAP) r.rd = shadow_vals[pos];
      else r.st = ST_RANGE;
    end else if (act == ACT_INSERT) begin
      if (shadow_len >= LIST_CAP) begin
        r.st = ST_FULL;
      end else if (pos > shadow_len) begin
        r.st = ST_RANGE;
      end else begin
        for (int unsigned i = shadow_len; i > pos; i--) shadow_vals[i] = shadow_vals[i-1];
        shadow_vals[pos] = val;
        shadow_len++;
      end
    end else if (act == ACT_REMOVE) begin
      if (pos < shadow_len && pos < LIST_CAP) begin
        for (int unsigned i = pos; i + 1 < shadow_len; i++) shadow_vals[i] = shadow_vals[i+1];
        shadow_len--;
      end else begin
        r.st = ST_RANGE;
      end
    end
    r.cnt = shadow_len[PosW-1:0];
    return r;
  endfunction

  task automatic add_directed(input logic [1:0] act, input int unsigned pos,
                              input logic [ValueW-1:0] val, input bit known,
                              input logic [ValueW-1:0] rd, input logic [1:0] st,
                              input int unsigned cnt);
    stim_row_t row;
    row.act = act;
    row.pos = pos[PosW-1:0];
    row.val = val;
    row.known = known;
    row.res.rd = rd;
    row.res.st = st;
    row.res.cnt = cnt[PosW-1:0];
    directed_rows.push_back(row);
  endtask

  task automatic send_item(input logic [1:0] act, input logic [PosW-1:0] pos,
                           input logic [ValueW-1:0] val, input bit known,
                           input list_result_t typed);
    list_result_t predicted;
    int unsigned gap;
    if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
      gap = $urandom_range(1, 4);
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    action <= act;
    position <= pos;
    value <= val;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predicted = apply_list_op(act, pos, val);
    expected_results.push_back(known ? typed : predicted);
  endtask

  initial begin : out_side
    int unsigned stall_left;
    stall_left = 0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else if (out_ready && idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
        stall_left = $urandom_range(1, 4) - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin : check_out
    list_result_t want;
    if (!rst && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        $error("result beat with nothing pending: read_value %0d status %0d entry_count %0d",
               read_value, status, entry_count);
        fail_count++;
      end else begin
        want = expected_results.pop_front();
        if (read_value !== want.rd) begin
          $error("read_value: expected %0d, got %0d", want.rd, read_value);
          fail_count++;
        end
        if (status !== want.st) begin
          $error("status: expected %0d, got %0d", want.st, status);
          fail_count++;
        end
        if (entry_count !== want.cnt) begin
          $error("entry_count: expected %0d, got %0d", want.cnt, entry_count);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin : stimulus
    int unsigned  sent;
    int unsigned  seg_left;
    int unsigned  pick;
    int unsigned  hi;
    mix_t         mode;
    logic [1:0]   r_act;
    logic [PosW-1:0] r_pos;
    logic [ValueW-1:0] r_val;
    list_result_t none_typed;

    rst = 1'b1;
    in_valid = 1'b0;
    action = ACT_READ;
    position = '0;
    value = '0;
    shadow_len = 0;
    none_typed = '0;

    add_directed(ACT_READ,   0,   32'd0,        1, 32'd0,        ST_RANGE, 0);
    add_directed(ACT_REMOVE, 0,   32'd0,        1, 32'd0,        ST_RANGE, 0);
    add_directed(ACT_INSERT, 1,   32'd1234,     1, 32'd0,        ST_RANGE, 0);
    add_directed(ACT_NONE,   127, 32'hFFFFFFFF, 1, 32'd0,        ST_OK,    0);
    add_directed(ACT_INSERT, 0,   32'h7FFFFFFF, 1, 32'd0,        ST_OK,    1);
    add_directed(ACT_INSERT, 0,   32'h80000000, 1, 32'd0,        ST_OK,    2);
    add_directed(ACT_INSERT, 2,   32'hFFFFFFFF, 1, 32'd0,        ST_OK,    3);
    add_directed(ACT_READ,   0,   32'd0,        1, 32'h80000000, ST_OK,    3);
    add_directed(ACT_READ,   2,   32'hFFFFFFFF, 1, 32'hFFFFFFFF, ST_OK,    3);
    add_directed(ACT_READ,   3,   32'd0,        1, 32'd0,        ST_RANGE, 3);
    add_directed(ACT_READ,   127, 32'd0,        1, 32'd0,        ST_RANGE, 3);
    add_directed(ACT_INSERT, 127, 32'd5,        1, 32'd0,        ST_RANGE, 3);
    add_directed(ACT_INSERT, 4,   32'd5,        1, 32'd0,        ST_RANGE, 3);
    add_directed(ACT_REMOVE, 127, 32'd0,        1, 32'd0,        ST_RANGE, 3);
    add_directed(ACT_REMOVE, 1,   32'd0,        1, 32'd0,        ST_OK,    2);
    add_directed(ACT_READ,   1,   32'd0,        1, 32'hFFFFFFFF, ST_OK,    2);
    add_directed(ACT_INSERT, 1,   32'h55555555, 0, 32'd0,        ST_OK,    0);
    add_directed(ACT_INSERT, 0,   32'hAAAAAAAA, 0, 32'd0,        ST_OK,    0);
    add_directed(ACT_READ,   2,   32'd0,        0, 32'd0,        ST_OK,    0);
    add_directed(ACT_REMOVE, 0,   32'd0,        0, 32'd0,        ST_OK,    0);
    add_directed(ACT_READ,   0,   32'd0,        0, 32'd0,        ST_OK,    0);
    add_directed(ACT_NONE,   0,   32'd0,        0, 32'd0,        ST_OK,    0);
    add_directed(ACT_REMOVE, 3,   32'd0,        0, 32'd0,        ST_OK,    0);
    add_directed(ACT_READ,   64,  32'd0,        0, 32'd0,        ST_OK,    0);

    repeat (11) @(negedge clk);
    rst <= 1'b0;
    idle_odds = 4;

    foreach (directed_rows[i])
      send_item(directed_rows[i].act, directed_rows[i].pos, directed_rows[i].val,
                directed_rows[i].known, directed_rows[i].res);
    sent = directed_rows.size();

    mode = GROW;
    seg_left = 90;
    while (sent < ITEM_TOTAL) begin
      if (seg_left == 0) begin
        mode = mix_t'($urandom_range(0, 2));
        seg_left = $urandom_range(20, 80);
        case ($urandom_range(0, 2))
          0: idle_odds = 0;
          1: idle_odds = 3;
          default: idle_odds = 6;
        endcase
      end
      if (ITEM_TOTAL - sent <= QUIET_TAIL) idle_odds = 0;

      pick = $urandom_range(0, 99);
      case (mode)
        GROW:
          r_act = pick < 75 ? ACT_INSERT : pick < 88 ? ACT_READ : pick < 97 ? ACT_REMOVE : ACT_NONE;
        SHRINK:
          r_act = pick < 80 ? ACT_REMOVE : pick < 90 ? ACT_READ : pick < 97 ? ACT_INSERT : ACT_NONE;
        default:
          r_act = pick < 35 ? ACT_INSERT : pick < 65 ? ACT_READ : pick < 95 ? ACT_REMOVE : ACT_NONE;
      endcase

      hi = (r_act == ACT_INSERT) ? shadow_len : (shadow_len == 0 ? 0 : shadow_len - 1);
      if (r_act == ACT_NONE)
        r_pos = PosW'($urandom_range(0, 127));
      else if ($urandom_range(0, 9) == 0 || (r_act != ACT_INSERT && shadow_len == 0))
        r_pos = PosW'($urandom_range(hi + 1, 127));
      else
        r_pos = PosW'($urandom_range(0, hi));

      if ($urandom_range(0, 7) == 0) begin
        case ($urandom_range(0, 3))
          0: r_val = 32'h7FFFFFFF;
          1: r_val = 32'h80000000;
          2: r_val = 32'h00000000;
          default: r_val = 32'hFFFFFFFF;
        endcase
      end else begin
        r_val = $urandom;
      end

      send_item(r_act, r_pos, r_val, 0, none_typed);
      sent++;
      seg_left--;
    end

    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
